>>> rtl/ilfi_pkg.sv
package ilfi_pkg;

    localparam int IRQ_COUNT      = 16;
    localparam int IRQ_BITS       = 4;
    localparam int RUN_COUNT_BITS = 32;
    localparam int QUEUE_DEPTH    = 2;
    localparam int QUEUE_PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [2:0] {
        REQ_LEVEL = 3'd0,
        REQ_PULSE = 3'd1,
        REQ_ARM   = 3'd2,
        REQ_RUN   = 3'd3,
        REQ_CLEAR = 3'd4
    } req_e;

    typedef enum logic {
        KIND_DROP = 1'b0,
        KIND_DUP  = 1'b1
    } kind_e;

    typedef enum logic {
        CFG_LINE_DRIVER = 1'b0,
        CFG_QUIET_CHECK = 1'b1
    } cfg_index_e;

    typedef struct packed {
        logic [IRQ_COUNT-1:0]      requested_lines;
        kind_e                     armed_kind;
        logic [IRQ_BITS-1:0]       armed_line;
        logic                      armed_flag;
        logic                      suppress_flag;
        logic                      replay_pending;
        logic [RUN_COUNT_BITS-1:0] run_count;
        logic [RUN_COUNT_BITS-1:0] replay_run;
    } fault_state_t;

    typedef struct packed {
        fault_state_t st;
        logic         drive;
    } level_out_t;

    typedef struct packed {
        logic                status;
        logic                drive_valid;
        logic [IRQ_BITS-1:0] drive_irq;
        logic                drive_level;
    } result_t;

    typedef struct packed {
        result_t r0;
        result_t r1;
        logic    two;
    } entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    // one validated level request against the fault state
    function automatic level_out_t apply_level(fault_state_t s, logic [IRQ_BITS-1:0] line,
                                               logic lev);
        level_out_t           r;
        logic [IRQ_COUNT-1:0] mask;
        logic                 prev_high;
        r.st      = s;
        r.drive   = 1'b0;
        mask      = IRQ_COUNT'(1) << line;
        prev_high = |(s.requested_lines & mask);
        if (lev)
        begin
            r.st.requested_lines = s.requested_lines | mask;
        end
        else
        begin
            r.st.requested_lines = s.requested_lines & ~mask;
        end
        if (s.suppress_flag && line == s.armed_line)
        begin
            if (!lev)
            begin
                r.st.suppress_flag = 1'b0;
                r.st.armed_kind    = KIND_DROP;
            end
        end
        else
        begin
            r.drive = 1'b1;
            if (s.armed_flag && line == s.armed_line && lev && !prev_high)
            begin
                r.st.armed_flag = 1'b0;
                if (s.armed_kind == KIND_DROP)
                begin
                    r.st.suppress_flag = 1'b1;
                    r.drive            = 1'b0;
                end
                else
                begin
                    r.st.replay_pending = 1'b1;
                    r.st.replay_run     = s.run_count + RUN_COUNT_BITS'(1);
                end
            end
        end
        return r;
    endfunction

    function automatic result_t drive_result(logic [IRQ_BITS-1:0] line, logic lev);
        result_t r;
        r.status      = 1'b0;
        r.drive_valid = 1'b1;
        r.drive_irq   = line;
        r.drive_level = lev;
        return r;
    endfunction

endpackage

>>> rtl/ilfi_queue.sv
module ilfi_queue (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  ilfi_pkg::entry_t       push_data,
    input  logic                   pop,
    output ilfi_pkg::entry_t       pop_data,
    output ilfi_pkg::queue_status_t q_status
);

    ilfi_pkg::entry_t                     entries_reg [ilfi_pkg::QUEUE_DEPTH];
    logic [ilfi_pkg::QUEUE_PTR_BITS-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [ilfi_pkg::QUEUE_PTR_BITS-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [ilfi_pkg::QUEUE_CNT_BITS-1:0]  count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (32'(wr_ptr_reg) == ilfi_pkg::QUEUE_DEPTH - 1) ? '0
                        : wr_ptr_reg + ilfi_pkg::QUEUE_PTR_BITS'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (32'(rd_ptr_reg) == ilfi_pkg::QUEUE_DEPTH - 1) ? '0
                        : rd_ptr_reg + ilfi_pkg::QUEUE_PTR_BITS'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + ilfi_pkg::QUEUE_CNT_BITS'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - ilfi_pkg::QUEUE_CNT_BITS'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign pop_data       = entries_reg[rd_ptr_reg];
    assign q_status.full  = (32'(count_reg) == ilfi_pkg::QUEUE_DEPTH);
    assign q_status.empty = (count_reg == '0);

endmodule

>>> rtl/ilfi_front.sv
module ilfi_front (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    input  logic                   cfg_index,
    input  logic                   cfg_data,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [2:0]             req_type,
    input  logic [3:0]             irq,
    input  logic                   level,
    input  logic [1:0]             fault_sel,
    input  logic                   line_quiet,
    input  logic                   quiet_error,
    input  ilfi_pkg::queue_status_t q_status,
    output logic                   push,
    output ilfi_pkg::entry_t       push_data
);

    ilfi_pkg::fault_state_t state_reg, state_next;
    logic                   line_drv_reg, quiet_chk_reg;
    ilfi_pkg::level_out_t   step_a, step_b;
    ilfi_pkg::entry_t       ent;
    logic                   err;
    logic                   line_bad;
    logic [ilfi_pkg::RUN_COUNT_BITS-1:0] run_inc;
    logic [ilfi_pkg::IRQ_COUNT-1:0]      armed_mask;

    assign in_stall = q_status.full;
    assign push     = in_valid && !in_stall;
    assign line_bad = (32'(irq) >= ilfi_pkg::IRQ_COUNT);
    assign run_inc  = state_reg.run_count + ilfi_pkg::RUN_COUNT_BITS'(1);
    assign armed_mask = ilfi_pkg::IRQ_COUNT'(1) << state_reg.armed_line;

    always_comb
    begin
        state_next = state_reg;
        ent        = '0;
        err        = 1'b0;
        step_a     = ilfi_pkg::apply_level(state_reg, irq, 1'b1);
        step_b     = ilfi_pkg::apply_level(step_a.st, irq, 1'b0);
        case (req_type)
            ilfi_pkg::REQ_LEVEL:
            begin
                if (!line_drv_reg || line_bad)
                begin
                    err = 1'b1;
                end
                else
                begin
                    step_a     = ilfi_pkg::apply_level(state_reg, irq, level);
                    state_next = step_a.st;
                    if (step_a.drive)
                    begin
                        ent.r0 = ilfi_pkg::drive_result(irq, level);
                    end
                end
            end
            ilfi_pkg::REQ_PULSE:
            begin
                if (!line_drv_reg || line_bad)
                begin
                    err = 1'b1;
                end
                else
                begin
                    state_next = step_b.st;
                    if (step_a.drive && step_b.drive)
                    begin
                        ent.r0  = ilfi_pkg::drive_result(irq, 1'b1);
                        ent.r1  = ilfi_pkg::drive_result(irq, 1'b0);
                        ent.two = 1'b1;
                    end
                    else if (step_a.drive)
                    begin
                        ent.r0 = ilfi_pkg::drive_result(irq, 1'b1);
                    end
                    else if (step_b.drive)
                    begin
                        ent.r0 = ilfi_pkg::drive_result(irq, 1'b0);
                    end
                end
            end
            ilfi_pkg::REQ_ARM:
            begin
                if (line_bad || fault_sel[1] || state_reg.armed_flag
                    || state_reg.suppress_flag || state_reg.replay_pending)
                begin
                    err = 1'b1;
                end
                else
                begin
                    state_next.armed_kind = ilfi_pkg::kind_e'(fault_sel[0]);
                    state_next.armed_line = irq;
                    state_next.armed_flag = 1'b1;
                end
            end
            ilfi_pkg::REQ_RUN:
            begin
                state_next.run_count = run_inc;
                if (state_reg.replay_pending && run_inc >= state_reg.replay_run
                    && !(|(state_reg.requested_lines & armed_mask)))
                begin
                    if (!quiet_chk_reg || quiet_error)
                    begin
                        err = 1'b1;
                    end
                    else if (line_quiet)
                    begin
                        if (!line_drv_reg)
                        begin
                            err = 1'b1;
                        end
                        else
                        begin
                            ent.r0  = ilfi_pkg::drive_result(state_reg.armed_line, 1'b1);
                            ent.r1  = ilfi_pkg::drive_result(state_reg.armed_line, 1'b0);
                            ent.two = 1'b1;
                            state_next.replay_pending = 1'b0;
                            state_next.armed_kind     = ilfi_pkg::KIND_DROP;
                        end
                    end
                end
            end
            ilfi_pkg::REQ_CLEAR:
            begin
                state_next.armed_kind     = ilfi_pkg::KIND_DROP;
                state_next.armed_line     = '0;
                state_next.armed_flag     = 1'b0;
                state_next.suppress_flag  = 1'b0;
                state_next.replay_pending = 1'b0;
                state_next.replay_run     = '0;
            end
            default:
            begin
                err = 1'b1;
            end
        endcase
        if (err)
        begin
            ent.r0.status = 1'b1;
        end
        push_data = ent;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= '0;
            line_drv_reg  <= 1'b1;
            quiet_chk_reg <= 1'b1;
        end
        else
        begin
            if (push)
            begin
                state_reg <= state_next;
            end
            if (cfg_valid)
            begin
                case (cfg_index)
                    ilfi_pkg::CFG_LINE_DRIVER: line_drv_reg  <= cfg_data;
                    ilfi_pkg::CFG_QUIET_CHECK: quiet_chk_reg <= cfg_data;
                    default:                   line_drv_reg  <= line_drv_reg;
                endcase
            end
        end
    end

endmodule

>>> rtl/ilfi_back.sv
module ilfi_back (
    input  logic                    clk,
    input  logic                    rst_n,
    input  ilfi_pkg::queue_status_t q_status,
    input  ilfi_pkg::entry_t        pop_data,
    output logic                    pop,
    output logic                    out_valid,
    input  logic                    out_stall,
    output ilfi_pkg::result_t       res,
    output logic                    last
);

    logic             busy_reg, busy_next;
    logic             phase_reg, phase_next;
    ilfi_pkg::entry_t ent_reg;
    logic             take;
    logic             done_item;

    assign take      = busy_reg && !out_stall;
    assign done_item = take && (phase_reg || !ent_reg.two);
    assign pop       = (!busy_reg || done_item) && !q_status.empty;

    always_comb
    begin
        busy_next  = busy_reg;
        phase_next = phase_reg;
        if (pop)
        begin
            busy_next  = 1'b1;
            phase_next = 1'b0;
        end
        else if (done_item)
        begin
            busy_next  = 1'b0;
            phase_next = 1'b0;
        end
        else if (take)
        begin
            phase_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            phase_reg <= 1'b0;
        end
        else
        begin
            busy_reg  <= busy_next;
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            ent_reg <= pop_data;
        end
    end

    assign out_valid = busy_reg;
    assign res       = phase_reg ? ent_reg.r1 : ent_reg.r0;
    assign last      = phase_reg || !ent_reg.two;

endmodule

>>> rtl/irq_line_fault_injector_unit.sv
// the first result is valid once its entry has been written into the queue and then loaded into the back register
// throughput: one item per cycle when it has one result and out_stall is low; a pulse or replay item
// gives its two results in turn, as the back part shows one result per cycle from its register while out_stall is low
// reset: asynchronous, active low; all line and fault state zero, both config bits set to 1
module irq_line_fault_injector_unit (
    input  logic       clk,
    input  logic       rst_n,
    // config write channel
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_index,
    input  logic       cfg_data,
    // request channel
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [2:0] req_type,
    input  logic [3:0] irq,
    input  logic       level,
    input  logic [1:0] fault_sel,
    input  logic       line_quiet,
    input  logic       quiet_error,
    // result channel
    output logic       out_valid,
    input  logic       out_stall,
    output logic       status,
    output logic       drive_valid,
    output logic [3:0] drive_irq,
    output logic       drive_level,
    output logic       last
);

    ilfi_pkg::queue_status_t q_status;
    ilfi_pkg::entry_t        push_data;
    ilfi_pkg::entry_t        pop_data;
    ilfi_pkg::result_t       res;
    logic                    push;
    logic                    pop;

    // config registers take every write at once
    assign cfg_ready = 1'b1;

    // front: classifies each request, updates the fault state and builds
    // the one or two results it causes, line drives or a bare status
    ilfi_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .req_type    (req_type),
        .irq         (irq),
        .level       (level),
        .fault_sel   (fault_sel),
        .line_quiet  (line_quiet),
        .quiet_error (quiet_error),
        .q_status    (q_status),
        .push        (push),
        .push_data   (push_data)
    );

    // short queue so the front keeps taking requests while a result waits
    ilfi_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .q_status  (q_status)
    );

    // back: plays out each queued entry, one result transfer per cycle while out_stall is low
    ilfi_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_status  (q_status),
        .pop_data  (pop_data),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .res       (res),
        .last      (last)
    );

    assign status      = res.status;
    assign drive_valid = res.drive_valid;
    assign drive_irq   = res.drive_irq;
    assign drive_level = res.drive_level;

    // second result of a pair follows right after the first
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last |=> out_valid)
        else $error("second result of a pair missing");

    // a result without a line drive is always the only one of its request
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !drive_valid |-> last)
        else $error("undriven result not last");

    // first of a pair raises the line
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last |-> drive_valid && drive_level)
        else $error("first of a pair does not raise the line");

    // errors never drive a line
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status |-> last && !drive_valid)
        else $error("error result drives a line");

endmodule

>>> tb/sv/tb_irq_line_fault_injector_unit.sv
`timescale 1ns / 1ps

module tb_irq_line_fault_injector_unit;

    // codes the package enums do not cover
    localparam logic [2:0] REQ_FIRST_UNKNOWN = 3'd5;
    localparam logic [2:0] REQ_LAST_UNKNOWN  = 3'd7;
    localparam logic [1:0] FK_DROP           = 2'd0;
    localparam logic [1:0] FK_DUP            = 2'd1;
    localparam logic [1:0] FK_BAD_LOW        = 2'd2;
    localparam logic [1:0] FK_BAD_HIGH       = 2'd3;

    // generous bound for ~750 items, also in the worst phases
    localparam int CYCLE_LIMIT    = 400000;
    localparam int MAX_REPORTED   = 10;
    localparam int SETTLE_CYCLES  = 4;

    // one request as it goes onto the input channel
    typedef struct packed {
        logic [2:0] req;
        logic [3:0] line;
        logic       lev;
        logic [1:0] kind;
        logic       quiet;
        logic       qerr;
    } irq_request_t;

    // one line drive result plus its end-of-request mark
    typedef struct packed {
        ilfi_pkg::result_t res;
        logic              last;
    } drive_rec_t;

    // ------------------------------------------------------------------
    // scoreboard: tracks line and fault state, predicts the drives that
    // each accepted request causes, and checks them in order
    // ------------------------------------------------------------------
    class irq_scoreboard;
        logic [ilfi_pkg::IRQ_COUNT-1:0]      req_lines;
        ilfi_pkg::kind_e                     armed_kind;
        logic [ilfi_pkg::IRQ_BITS-1:0]       armed_line;
        bit                                  armed;
        bit                                  suppress;
        bit                                  replay_pending;
        logic [ilfi_pkg::RUN_COUNT_BITS-1:0] run_count;
        logic [ilfi_pkg::RUN_COUNT_BITS-1:0] replay_run;
        bit                                  driver_on;
        bit                                  quiet_check_on;
        drive_rec_t                          staged[$];
        drive_rec_t                          pending_drives[$];
        int                                  mismatches;

        function new();
            driver_on      = 1'b1;
            quiet_check_on = 1'b1;
            req_lines      = '0;
            run_count      = '0;
            mismatches     = 0;
            clear_fault();
        endfunction

        function void clear_fault();
            armed_kind     = ilfi_pkg::KIND_DROP;
            armed_line     = '0;
            armed          = 1'b0;
            suppress       = 1'b0;
            replay_pending = 1'b0;
            replay_run     = '0;
        endfunction

        function void set_register(ilfi_pkg::cfg_index_e idx, logic val);
            case (idx)
                ilfi_pkg::CFG_LINE_DRIVER: driver_on      = val;
                ilfi_pkg::CFG_QUIET_CHECK: quiet_check_on = val;
                default: ;
            endcase
        endfunction

        function void add_drive(logic [ilfi_pkg::IRQ_BITS-1:0] line, logic lev);
            drive_rec_t rec;
            rec.res.status      = 1'b0;
            rec.res.drive_valid = 1'b1;
            rec.res.drive_irq   = line;
            rec.res.drive_level = lev;
            rec.last            = 1'b0;
            staged.push_back(rec);
        endfunction

        // updates the line and fault state for one level change;
        // returns 1 when the change goes out on the line
        function bit update_line(logic [ilfi_pkg::IRQ_BITS-1:0] line, logic lev);
            logic [ilfi_pkg::IRQ_COUNT-1:0] mask;
            bit                             prev_high;
            mask      = ilfi_pkg::IRQ_COUNT'(1) << line;
            prev_high = (req_lines & mask) != '0;
            if (lev)
                req_lines = req_lines | mask;
            else
                req_lines = req_lines & ~mask;
            // drop-once: line stays silent until it is requested low
            if (suppress && line == armed_line)
            begin
                if (!lev)
                begin
                    suppress   = 1'b0;
                    armed_kind = ilfi_pkg::KIND_DROP;
                end
                return 1'b0;
            end
            // rising edge on the armed line fires the fault
            if (armed && line == armed_line && lev && !prev_high)
            begin
                armed = 1'b0;
                if (armed_kind == ilfi_pkg::KIND_DROP)
                begin
                    suppress = 1'b1;
                    return 1'b0;
                end
                replay_pending = 1'b1;
                replay_run     = run_count + ilfi_pkg::RUN_COUNT_BITS'(1);
            end
            return 1'b1;
        endfunction

        // works out the drives of one accepted request and queues them
        function void predict_line_drives(irq_request_t r);
            logic       st;
            drive_rec_t rec;
            st = 1'b0;
            staged.delete();
            case (r.req)
                ilfi_pkg::REQ_LEVEL:
                begin
                    if (!driver_on)
                        st = 1'b1;
                    else if (update_line(r.line, r.lev))
                        add_drive(r.line, r.lev);
                end
                ilfi_pkg::REQ_PULSE:
                begin
                    if (!driver_on)
                        st = 1'b1;
                    else
                    begin
                        if (update_line(r.line, 1'b1))
                            add_drive(r.line, 1'b1);
                        if (update_line(r.line, 1'b0))
                            add_drive(r.line, 1'b0);
                    end
                end
                ilfi_pkg::REQ_ARM:
                begin
                    if (r.kind > FK_DUP || armed || suppress || replay_pending)
                        st = 1'b1;
                    else
                    begin
                        armed_kind = ilfi_pkg::kind_e'(r.kind[0]);
                        armed_line = r.line;
                        armed      = 1'b1;
                    end
                end
                ilfi_pkg::REQ_RUN:
                begin
                    run_count = run_count + ilfi_pkg::RUN_COUNT_BITS'(1);
                    if (replay_pending && run_count >= replay_run && !req_lines[armed_line])
                    begin
                        if (!quiet_check_on || r.qerr)
                            st = 1'b1;
                        else if (r.quiet)
                        begin
                            if (!driver_on)
                                st = 1'b1;
                            else
                            begin
                                add_drive(armed_line, 1'b1);
                                add_drive(armed_line, 1'b0);
                                replay_pending = 1'b0;
                                armed_kind     = ilfi_pkg::KIND_DROP;
                            end
                        end
                    end
                end
                ilfi_pkg::REQ_CLEAR: clear_fault();
                default: st = 1'b1;
            endcase
            if (staged.size() == 0)
            begin
                rec       = '0;
                rec.res.status = st;
                staged.push_back(rec);
            end
            rec      = staged.pop_back();
            rec.last = 1'b1;
            staged.push_back(rec);
            foreach (staged[i])
                pending_drives.push_back(staged[i]);
        endfunction

        function void flag_mismatch(string what, drive_rec_t want, drive_rec_t got);
            mismatches++;
            if (mismatches <= MAX_REPORTED)
                $display({"%0t %s: expected st %0d dv %0d irq %0d lvl %0d last %0d,",
                          " got st %0d dv %0d irq %0d lvl %0d last %0d"},
                         $realtime, what,
                         want.res.status, want.res.drive_valid, want.res.drive_irq,
                         want.res.drive_level, want.last,
                         got.res.status, got.res.drive_valid, got.res.drive_irq,
                         got.res.drive_level, got.last);
        endfunction

        function void check_result(drive_rec_t got);
            drive_rec_t want;
            if (pending_drives.size() == 0)
            begin
                flag_mismatch("unexpected result", '0, got);
                return;
            end
            want = pending_drives.pop_front();
            if (got.res.status !== want.res.status ||
                got.res.drive_valid !== want.res.drive_valid ||
                got.res.drive_irq !== want.res.drive_irq ||
                got.res.drive_level !== want.res.drive_level ||
                got.last !== want.last)
                flag_mismatch("result mismatch", want, got);
        endfunction
    endclass

    // ------------------------------------------------------------------
    // dut signals
    // ------------------------------------------------------------------
    logic       clk = 1'b0;
    logic       rst_n;
    logic       cfg_valid;
    logic       cfg_ready;
    logic       cfg_index;
    logic       cfg_data;
    logic       in_valid;
    logic       in_stall;
    logic [2:0] req_type;
    logic [3:0] irq;
    logic       level;
    logic [1:0] fault_sel;
    logic       line_quiet;
    logic       quiet_error;
    logic       out_valid;
    logic       out_stall;
    logic       status;
    logic       drive_valid;
    logic [3:0] drive_irq;
    logic       drive_level;
    logic       last;

    irq_scoreboard sb;
    int            send_idle_pct;
    int            recv_stall_pct;
    int            items_sent;
    int            cycle_count;

    irq_line_fault_injector_unit u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .req_type    (req_type),
        .irq         (irq),
        .level       (level),
        .fault_sel   (fault_sel),
        .line_quiet  (line_quiet),
        .quiet_error (quiet_error),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .drive_valid (drive_valid),
        .drive_irq   (drive_irq),
        .drive_level (drive_level),
        .last        (last)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // run watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("irq_line_fault_injector_unit regression: fail");
            $finish;
        end
    end

    // receiver back-pressure, rate set per phase
    always @(posedge clk)
    begin
        out_stall <= rst_n && ($urandom_range(99) < recv_stall_pct);
    end

    // result monitor: a transfer completes when valid is high and stall is low
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result('{res: '{status, drive_valid, drive_irq, drive_level},
                              last: last});
    end

    // ------------------------------------------------------------------
    // stimulus helpers; each is entered and left in the step of a rising edge
    // ------------------------------------------------------------------
    function automatic irq_request_t make_request(logic [2:0] req, logic [3:0] line,
                                                  logic lev, logic [1:0] kind,
                                                  logic quiet, logic qerr);
        irq_request_t r;
        r = '{req, line, lev, kind, quiet, qerr};
        return r;
    endfunction

    // every field random; unknown request codes now and then
    function automatic irq_request_t random_request();
        irq_request_t r;
        if ($urandom_range(99) < 8)
            r.req = 3'($urandom_range(REQ_LAST_UNKNOWN, REQ_FIRST_UNKNOWN));
        else
            r.req = 3'($urandom_range(ilfi_pkg::REQ_CLEAR, ilfi_pkg::REQ_LEVEL));
        r.line  = 4'($urandom_range(ilfi_pkg::IRQ_COUNT - 1));
        r.lev   = 1'($urandom_range(1));
        r.kind  = 2'($urandom_range(FK_BAD_HIGH, FK_DROP));
        r.quiet = 1'($urandom_range(1));
        r.qerr  = 1'($urandom_range(1));
        return r;
    endfunction

    // one input transfer, with optional sender gaps ahead of it
    task automatic send_request(irq_request_t r);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        req_type    <= r.req;
        irq         <= r.line;
        level       <= r.lev;
        fault_sel   <= r.kind;
        line_quiet  <= r.quiet;
        quiet_error <= r.qerr;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.predict_line_drives(r);
        items_sent++;
    endtask

    // config writes leave cfg_valid high; the caller lowers it after the last one
    task automatic write_config(ilfi_pkg::cfg_index_e idx, logic val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.set_register(idx, val);
    endtask

    // stop sending and let every outstanding result come back
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending_drives.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // well-formed fault scenario: arm, hit the line, then run completions
    task automatic fault_sequence();
        irq_request_t r;
        logic [3:0]   line;
        line = 4'($urandom_range(ilfi_pkg::IRQ_COUNT - 1));
        // usually start from a clean fault state so the arm gets through
        if ($urandom_range(99) < 70)
        begin
            r     = random_request();
            r.req = ilfi_pkg::REQ_CLEAR;
            send_request(r);
        end
        r      = random_request();
        r.req  = ilfi_pkg::REQ_ARM;
        r.line = line;
        r.kind = ($urandom_range(9) == 0) ? 2'($urandom_range(FK_BAD_HIGH, FK_BAD_LOW))
                                          : 2'($urandom_range(FK_DUP, FK_DROP));
        send_request(r);
        repeat ($urandom_range(6, 2))
        begin
            r = random_request();
            case ($urandom_range(5))
                0, 1:
                begin
                    r.req  = ilfi_pkg::REQ_LEVEL;
                    r.line = line;
                end
                2:
                begin
                    r.req  = ilfi_pkg::REQ_PULSE;
                    r.line = line;
                end
                3:
                begin
                    r.req  = ilfi_pkg::REQ_LEVEL;
                    r.line = line;
                    r.lev  = 1'b0;
                end
                4:
                begin
                    r.req   = ilfi_pkg::REQ_RUN;
                    r.quiet = ($urandom_range(99) < 80);
                    r.qerr  = ($urandom_range(99) < 10);
                end
                default: ;   // leave as noise
            endcase
            send_request(r);
        end
        // bring the line low so a pending replay can go out
        r      = random_request();
        r.req  = ilfi_pkg::REQ_LEVEL;
        r.line = line;
        r.lev  = 1'b0;
        send_request(r);
        repeat ($urandom_range(3, 1))
        begin
            r       = random_request();
            r.req   = ilfi_pkg::REQ_RUN;
            r.quiet = ($urandom_range(99) < 85);
            r.qerr  = ($urandom_range(99) < 10);
            send_request(r);
        end
    endtask

    // one random phase under one register setting and one idling pattern
    task automatic run_phase(logic drv_on, logic quiet_on, int send_pct, int stall_pct,
                             int n_items);
        int target;
        target = items_sent + n_items;
        write_config(ilfi_pkg::CFG_LINE_DRIVER, drv_on);
        write_config(ilfi_pkg::CFG_QUIET_CHECK, quiet_on);
        cfg_valid      <= 1'b0;
        send_idle_pct  = send_pct;
        recv_stall_pct = stall_pct;
        while (items_sent < target)
        begin
            if ($urandom_range(99) < 75)
                fault_sequence();
            else
                send_request(random_request());
        end
        drain();
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin
        sb             = new();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        items_sent     = 0;
        cycle_count    = 0;
        rst_n          = 1'b0;
        cfg_valid      = 1'b0;
        cfg_index      = 1'b0;
        cfg_data       = 1'b0;
        in_valid       = 1'b0;
        req_type       = '0;
        irq            = '0;
        level          = 1'b0;
        fault_sel      = '0;
        line_quiet     = 1'b0;
        quiet_error    = 1'b0;
        out_stall      = 1'b0;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part at the reset register values
        // plain levels and pulses at both ends of the line range
        send_request(make_request(ilfi_pkg::REQ_LEVEL, 4'd0,  1'b1, FK_DROP, 1'b0, 1'b0));
        send_request(make_request(ilfi_pkg::REQ_LEVEL, 4'd0,  1'b0, FK_DROP, 1'b0, 1'b0));
        send_request(make_request(ilfi_pkg::REQ_LEVEL, 4'd15, 1'b1, FK_DROP, 1'b0, 1'b0));
        send_request(make_request(ilfi_pkg::REQ_PULSE, 4'd15, 1'b0, FK_DROP, 1'b0, 1'b0));
        send_request(make_request(ilfi_pkg::REQ_LEVEL, 4'd15, 1'b0, FK_DROP, 1'b0, 1'b0));
        // rejected fault kinds and unknown request codes
        send_request(make_request(ilfi_pkg::REQ_ARM, 4'd3, 1'b0, FK_BAD_LOW,  1'b0, 1'b0));
        send_request(make_request(ilfi_pkg::REQ_ARM, 4'd3, 1'b0, FK_BAD_HIGH, 1'b0, 1'b0));
        send_request(make_request(REQ_FIRST_UNKNOWN, 4'd0, 1'b0, FK_DROP, 1'b0, 1'b0));
        send_request(make_request(REQ_LAST_UNKNOWN, 4'd15, 1'b1, FK_BAD_HIGH, 1'b1, 1'b1));
        // drop once: edge swallowed, pulse stays silent and releases the line
        send_request(make_request(ilfi_pkg::REQ_ARM,   4'd3, 1'b0, FK_DROP, 1'b0, 1'b0));
        send_request(make_request(ilfi_pkg::REQ_LEVEL, 4'd3, 1'b1, FK_DROP, 1'b0, 1'b0));
        send_request(make_request(ilfi_pkg::REQ_PULSE, 4'd3, 1'b0, FK_DROP, 1'b0, 1'b0));
        send_request(make_request(ilfi_pkg::REQ_LEVEL, 4'd3, 1'b1, FK_DROP, 1'b0, 1'b0));
        send_request(make_request(ilfi_pkg::REQ_LEVEL, 4'd3, 1'b0, FK_DROP, 1'b0, 1'b0));
        // duplicate once, arming while busy, then each way a due replay holds off
        send_request(make_request(ilfi_pkg::REQ_ARM,   4'd15, 1'b0, FK_DUP,  1'b0, 1'b0));
        send_request(make_request(ilfi_pkg::REQ_ARM,   4'd4,  1'b0, FK_DROP, 1'b0, 1'b0));
        send_request(make_request(ilfi_pkg::REQ_LEVEL, 4'd15, 1'b1, FK_DROP, 1'b0, 1'b0));
        send_request(make_request(ilfi_pkg::REQ_RUN,   4'd0,  1'b0, FK_DROP, 1'b1, 1'b0));
        send_request(make_request(ilfi_pkg::REQ_LEVEL, 4'd15, 1'b0, FK_DROP, 1'b0, 1'b0));
        send_request(make_request(ilfi_pkg::REQ_RUN,   4'd0,  1'b0, FK_DROP, 1'b0, 1'b0));
        send_request(make_request(ilfi_pkg::REQ_RUN,   4'd0,  1'b0, FK_DROP, 1'b1, 1'b1));
        send_request(make_request(ilfi_pkg::REQ_RUN,   4'd0,  1'b0, FK_DROP, 1'b1, 1'b0));
        // duplicate fired by a pulse, then cleared before any run
        send_request(make_request(ilfi_pkg::REQ_ARM,   4'd0, 1'b0, FK_DUP,  1'b0, 1'b0));
        send_request(make_request(ilfi_pkg::REQ_PULSE, 4'd0, 1'b0, FK_DROP, 1'b0, 1'b0));
        send_request(make_request(ilfi_pkg::REQ_CLEAR, 4'd0, 1'b0, FK_DROP, 1'b0, 1'b0));
        drain();

        // random phases: register setting, sender idle %, receiver stall %, items
        run_phase(1'b1, 1'b1,  0,  0, 170);
        run_phase(1'b1, 1'b0, 50,  0, 150);
        run_phase(1'b1, 1'b1,  0, 50, 170);
        run_phase(1'b0, 1'b1, 10, 10, 100);
        run_phase(1'b1, 1'b1, 10, 10, 110);
        run_phase(1'b0, 1'b0,  0,  0,  50);

        if (sb.pending_drives.size() != 0)
        begin
            $display("%0d expected results never arrived", sb.pending_drives.size());
            sb.mismatches++;
        end
        if (sb.mismatches == 0)
            $display("irq_line_fault_injector_unit regression: pass");
        else
            $display("irq_line_fault_injector_unit regression: fail");
        $finish;
    end

endmodule
